/* rtl/huffman_code_bit_packer_macros.svh */
// assertion macros shared by the packer modules
`ifndef HUFFMAN_CODE_BIT_PACKER_MACROS_SVH
`define HUFFMAN_CODE_BIT_PACKER_MACROS_SVH

// clocked check, off while reset is held
`define HCBP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check, also active during reset
`define HCBP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/hcbp_pkg.sv */
// shared types and constants of the huffman code bit packer
package hcbp_pkg;

  localparam logic [1:0] MODE_LOAD   = 2'd0;
  localparam logic [1:0] MODE_ENCODE = 2'd1;
  localparam logic [1:0] MODE_FLUSH  = 2'd2;

  localparam int unsigned WORD_BITS   = 32;
  localparam int unsigned QUEUE_DEPTH = 4;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

/* rtl/hcbp_ram.sv */
// generic single write port ram with registered read
module hcbp_ram #(
  parameter int unsigned WIDTH = 38,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/hcbp_front.sv */
// front end: accepts beats, updates the code table, queues encode and flush work
`include "huffman_code_bit_packer_macros.svh"

module hcbp_front #(
  parameter int unsigned SYMBOL_COUNT = 256,
  parameter int unsigned WORD_W       = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          in_mode,
  input  logic [7:0]                          in_symbol,
  input  logic [31:0]                         in_code_value,
  input  logic [5:0]                          in_code_length,
  input  hcbp_pkg::q_status_t                 q_st,
  output logic                                push,
  output logic [WORD_W+$clog2(WORD_W+1):0]    push_data
);

  localparam int unsigned LEN_W = $clog2(WORD_W + 1);
  localparam int unsigned AW    = $clog2(SYMBOL_COUNT);
  localparam int unsigned RAM_W = WORD_W + LEN_W;

  logic [SYMBOL_COUNT-1:0] valid_r, valid_nxt;
  logic                    s1_v_r, s1_v_nxt;
  logic                    s1_flush_r, s1_flush_nxt;
  logic                    s1_hit_r, s1_hit_nxt;

  logic              accept;
  logic              in_range;
  logic [AW-1:0]     addr;
  logic [LEN_W-1:0]  len_sat;
  logic              wr_en;
  logic              rd_en;
  logic [RAM_W-1:0]  rd_data;
  logic [WORD_W-1:0] rd_word;
  logic [LEN_W-1:0]  rd_len;
  logic              push_needed;
  logic              s1_done;

  assign addr     = in_symbol[AW-1:0];
  assign in_range = {1'b0, in_symbol} < 9'(SYMBOL_COUNT);
  assign len_sat  = (in_code_length > 6'(WORD_W)) ? LEN_W'(WORD_W) : LEN_W'(in_code_length);

  assign rd_word = rd_data[LEN_W +: WORD_W];
  assign rd_len  = rd_data[LEN_W-1:0];

  assign push_needed = s1_flush_r || (s1_hit_r && (rd_len != '0));
  assign s1_done     = s1_v_r && (!push_needed || !q_st.full);
  assign push        = s1_v_r && push_needed && !q_st.full;
  assign push_data   = {s1_flush_r, rd_word, rd_len};

  assign in_ready = !s1_v_r || s1_done;
  assign accept   = in_valid && in_ready;
  assign wr_en    = accept && (in_mode == hcbp_pkg::MODE_LOAD) && in_range;
  assign rd_en    = accept && (in_mode == hcbp_pkg::MODE_ENCODE) && in_range;

  hcbp_ram #(
    .WIDTH (RAM_W),
    .DEPTH (SYMBOL_COUNT)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (addr),
    .wdata ({in_code_value[WORD_W-1:0], len_sat}),
    .re    (rd_en),
    .raddr (addr),
    .rdata (rd_data)
  );

  always_comb begin
    valid_nxt    = valid_r;
    s1_v_nxt     = s1_v_r && !s1_done;
    s1_flush_nxt = s1_flush_r;
    s1_hit_nxt   = s1_hit_r;
    if (wr_en) begin
      valid_nxt[addr] = 1'b1;
    end
    if (rd_en) begin
      s1_v_nxt     = 1'b1;
      s1_flush_nxt = 1'b0;
      s1_hit_nxt   = valid_r[addr];
    end
    if (accept && (in_mode == hcbp_pkg::MODE_FLUSH)) begin
      s1_v_nxt     = 1'b1;
      s1_flush_nxt = 1'b1;
      s1_hit_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      s1_v_r  <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      s1_v_r  <= s1_v_nxt;
    end
    s1_flush_r <= s1_flush_nxt;
    s1_hit_r   <= s1_hit_nxt;
  end

  `HCBP_ASSERT(a_stall_has_work, !in_ready |-> s1_v_r, "front stalled with no pending beat")
  `HCBP_ASSERT(a_push_once, push && s1_flush_r |=> !(push && $past(in_ready) == 1'b0), "flush pushed twice")

endmodule

/* rtl/hcbp_queue.sv */
// short command queue between front and back
`include "huffman_code_bit_packer_macros.svh"

module hcbp_queue #(
  parameter int unsigned WIDTH = 39
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  logic [WIDTH-1:0]    push_data,
  input  logic                pop,
  output logic [WIDTH-1:0]    head_data,
  output hcbp_pkg::q_status_t q_st
);

  localparam int unsigned PTR_W = $clog2(hcbp_pkg::QUEUE_DEPTH);

  logic [WIDTH-1:0] entries_r [hcbp_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W:0]   count_r, count_nxt;

  assign q_st.full  = count_r == (PTR_W+1)'(hcbp_pkg::QUEUE_DEPTH);
  assign q_st.empty = count_r == '0;
  assign head_data  = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push) begin
      entries_r[wr_ptr_r] <= push_data;
    end
  end

  `HCBP_ASSERT(a_no_overflow, q_st.full |-> !push, "push into a full queue")
  `HCBP_ASSERT(a_no_underflow, q_st.empty |-> !pop, "pop from an empty queue")

endmodule

/* rtl/hcbp_back.sv */
// back end: shifts code bits into the partial byte and drives the output register
`include "huffman_code_bit_packer_macros.svh"

module hcbp_back #(
  parameter int unsigned WORD_W = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  hcbp_pkg::q_status_t              q_st,
  input  logic [WORD_W+$clog2(WORD_W+1):0] head_data,
  output logic                             pop,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [7:0]                       out_byte,
  output logic                             out_last
);

  localparam int unsigned LEN_W = $clog2(WORD_W + 1);

  logic              busy_r, busy_nxt;
  logic [LEN_W-1:0]  rem_r, rem_nxt;
  logic [WORD_W-1:0] sr_r, sr_nxt;
  logic [7:0]        partial_r, partial_nxt;
  logic [2:0]        pos_r, pos_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_byte_r, out_byte_nxt;
  logic              out_last_r, out_last_nxt;

  logic              head_flush;
  logic [WORD_W-1:0] head_word;
  logic [LEN_W-1:0]  head_len;
  logic [LEN_W-1:0]  shamt;
  logic              out_free;
  logic              step;
  logic              emit;
  logic [3:0]        free_bits;
  logic [3:0]        n;
  logic [7:0]        chunk;
  logic [7:0]        merged;

  assign head_flush = head_data[WORD_W+LEN_W];
  assign head_word  = head_data[LEN_W +: WORD_W];
  assign head_len   = head_data[LEN_W-1:0];
  assign shamt      = LEN_W'(WORD_W) - head_len;

  assign out_free = !out_valid_r || out_ready;
  assign pop      = !busy_r && !q_st.empty && (!head_flush || out_free);
  assign step     = busy_r && out_free;

  assign free_bits = {1'b0, pos_r} + 4'd1;
  assign n         = (rem_r < LEN_W'(free_bits)) ? rem_r[3:0] : free_bits;
  assign chunk     = sr_r[WORD_W-1 -: 8] & ~(8'hFF >> n);
  assign merged    = partial_r | (chunk >> (3'd7 - pos_r));

  always_comb begin
    busy_nxt      = busy_r;
    rem_nxt       = rem_r;
    sr_nxt        = sr_r;
    partial_nxt   = partial_r;
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    emit          = 1'b0;
    if (pop) begin
      if (head_flush) begin
        if (pos_r != 3'd7) begin
          emit         = 1'b1;
          out_byte_nxt = partial_r;
          out_last_nxt = 1'b1;
          partial_nxt  = '0;
          pos_nxt      = 3'd7;
        end
      end else begin
        sr_nxt   = head_word << shamt;
        rem_nxt  = head_len;
        busy_nxt = 1'b1;
      end
    end
    if (step) begin
      sr_nxt   = sr_r << n;
      rem_nxt  = rem_r - LEN_W'(n);
      busy_nxt = (rem_r - LEN_W'(n)) != '0;
      if (n == free_bits) begin
        emit         = 1'b1;
        out_byte_nxt = merged;
        out_last_nxt = 1'b0;
        partial_nxt  = '0;
        pos_nxt      = 3'd7;
      end else begin
        partial_nxt = merged;
        pos_nxt     = pos_r - n[2:0];
      end
    end
    if (emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      rem_r       <= '0;
      partial_r   <= '0;
      pos_r       <= 3'd7;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      rem_r       <= rem_nxt;
      partial_r   <= partial_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
    sr_r       <= sr_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

  `HCBP_ASSERT(a_emit_restarts_byte, emit |=> (pos_r == 3'd7) && (partial_r == 8'd0), "byte not restarted after emit")
  `HCBP_ASSERT(a_busy_no_pop, busy_r |-> !pop, "queue popped while a code is in flight")
  `HCBP_ASSERT_ALWAYS(a_busy_has_bits, busy_r |-> (rem_r != '0), "busy with no code bits left")

endmodule

/* rtl/huffman_code_bit_packer.sv */
// top level of the huffman code bit packer
//
//  channel  direction  handshake              payload
//  in       input      in_valid / in_ready    in_mode in_symbol in_code_value in_code_length
//  out      output     out_valid / out_ready  out_byte out_last
//
// load and mode 3 beats finish in the front when accepted; encode and flush beats
// pass a front stage (table read) and then a four entry queue.
// the back takes a code from the queue, then makes one step per output byte the code
// touches: ceil((bits + 7 - bit position) / 8) steps; a flush emits any partial byte.
// reset clears the table valid bits directly, so there is no clearing pass.
// a stalled output register halts the back's steps and flushes; the front keeps
// taking beats until the queue fills.
module huffman_code_bit_packer #(
  parameter int unsigned MAX_CODE_BITS = 32,
  parameter int unsigned SYMBOL_COUNT  = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [7:0]  in_symbol,
  input  logic [31:0] in_code_value,
  input  logic [5:0]  in_code_length,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_last
);

  localparam int unsigned WORD_W = (MAX_CODE_BITS < hcbp_pkg::WORD_BITS) ?
                                   MAX_CODE_BITS : hcbp_pkg::WORD_BITS;
  localparam int unsigned LEN_W  = $clog2(WORD_W + 1);
  localparam int unsigned QW     = 1 + WORD_W + LEN_W;

  hcbp_pkg::q_status_t q_st;
  logic                push;
  logic [QW-1:0]       push_data;
  logic                pop;
  logic [QW-1:0]       head_data;

  hcbp_front #(
    .SYMBOL_COUNT (SYMBOL_COUNT),
    .WORD_W       (WORD_W)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mode        (in_mode),
    .in_symbol      (in_symbol),
    .in_code_value  (in_code_value),
    .in_code_length (in_code_length),
    .q_st           (q_st),
    .push           (push),
    .push_data      (push_data)
  );

  hcbp_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head_data (head_data),
    .q_st      (q_st)
  );

  hcbp_back #(
    .WORD_W (WORD_W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_st      (q_st),
    .head_data (head_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

endmodule
